@@ hw/rtl/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the start character frame receiver.
// ----------------------------------------------------------------------------
package scr_pkg;

	// Payload buffer size in bytes.
	localparam int PAYLOAD_DEPTH = 32;
	localparam int CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
	localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	// Width of the payload length result field.
	localparam int LEN_W  = 6;

	localparam int JOBQ_DEPTH = 2;

	localparam logic [7:0]  START_CHAR_RST   = 8'd35;
	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd500;
	localparam logic [7:0]  ACK_CHAR         = 8'd48;

	localparam logic CFG_START_CHAR   = 1'b0;
	localparam logic CFG_IDLE_TIMEOUT = 1'b1;

	typedef enum logic {
		ACT_BYTE = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_ACK = 2'd0,
		KIND_CMD = 2'd1,
		KIND_PAY = 2'd2
	} kind_t;

	// One job for the output side: a byte acknowledge or a finished frame.
	typedef struct packed {
		logic             frame;
		logic [7:0]       cmd;
		logic [LEN_W-1:0] len;
	} job_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage

@@ hw/rtl/start_char_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// start_char_frame_receiver
// Start character delimited serial frame receiver with an idle timeout.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one request per received byte
// (s_tuser = 0, byte in s_tdata) or per timer tick (s_tuser = 1).
// Every byte request yields one acknowledge result ('0', kind 0). After the
// start character the next byte is the command and later bytes are payload
// (up to PAYLOAD_DEPTH, extra bytes are acknowledged but dropped). When the
// ticks since the last byte reach idle_timeout during payload loading, the
// block emits the command (kind 1, with payload length) and then the
// payload bytes (kind 2), the final one with tlast set.
// Each result passes through the job queue and then the output register.
// Throughput: one request per cycle, limited by the two-entry job queue.
// A frame drains at one result per cycle from the payload RAM while the
// output is not stalled; the input is stalled from the timeout tick until
// its final result is registered.
// A stalled output holds its result; the job queue then fills and the input
// stalls once two further requests that produce results are queued. Reset
// returns to waiting for the start character with start_char 35 and
// idle_timeout 500; payload RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module start_char_frame_receiver import scr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] value, [13:8] payload_len, [15:14] zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head;
	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	logic [7:0] ram_rdata;
	logic    frame_done;

	scr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job),
		.ram_wr     (ram_wr),
		.frame_done (frame_done)
	);

	scr_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	scr_ram #(
		.WIDTH (8),
		.DEPTH (PAYLOAD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	scr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.ram_rd     (ram_rd),
		.ram_rdata  (ram_rdata),
		.frame_done (frame_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

@@ hw/rtl/scr_ram.sv @@
// ----------------------------------------------------------------------------
// scr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module scr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/scr_front.sv @@
// ----------------------------------------------------------------------------
// scr_front
// Input side: frame parser, idle timer, payload writes and job generation.
// ----------------------------------------------------------------------------
module scr_front import scr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job,
	output ram_wr_t     ram_wr,
	input  logic        frame_done
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_CMD  = 3'b010,
		PH_DATA = 3'b100
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       start_char_q;
	logic [15:0]      idle_timeout_q;
	logic [7:0]       command_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      idle_q;
	logic             busy_q;

	logic        accept;
	logic        is_tick;
	logic [15:0] idle_inc;
	logic        timeout;
	logic        room;

	always_comb begin
		s_tready = !q_full && !busy_q;
		accept   = s_tvalid && s_tready;
		is_tick  = (s_tuser == ACT_TICK);
		idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		timeout  = (idle_inc >= idle_timeout_q);
		room     = (count_q < CNT_W'(PAYLOAD_DEPTH));

		push          = 1'b0;
		push_job      = '0;
		if (accept && !is_tick) begin
			push = 1'b1;
		end else if (accept && phase_q == PH_DATA && timeout) begin
			push           = 1'b1;
			push_job.frame = 1'b1;
			push_job.cmd   = command_q;
			push_job.len   = LEN_W'(count_q);
		end

		ram_wr.we   = accept && !is_tick && phase_q == PH_DATA && room;
		ram_wr.addr = count_q[ADDR_W-1:0];
		ram_wr.data = s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q   <= START_CHAR_RST;
			idle_timeout_q <= IDLE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_CHAR:   start_char_q   <= cfg_wdata[7:0];
				CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			command_q <= '0;
			count_q   <= '0;
			idle_q    <= '0;
			busy_q    <= 1'b0;
		end else begin
			if (frame_done) begin
				busy_q <= 1'b0;
			end
			if (accept && !is_tick) begin
				case (phase_q)
					PH_CMD: begin
						command_q <= s_tdata;
						idle_q    <= '0;
						phase_q   <= PH_DATA;
					end
					PH_DATA: begin
						if (room) begin
							count_q <= CNT_W'(count_q + 1'b1);
						end
						idle_q <= '0;
					end
					default: begin
						if (s_tdata == start_char_q) begin
							idle_q  <= '0;
							phase_q <= PH_CMD;
						end
					end
				endcase
			end else if (accept && phase_q != PH_IDLE) begin
				if (timeout) begin
					// A frame still loading its command is dropped silently.
					phase_q <= PH_IDLE;
					count_q <= '0;
					idle_q  <= '0;
					if (phase_q == PH_DATA) begin
						busy_q <= 1'b1;
					end
				end else begin
					idle_q <= idle_inc;
				end
			end
		end
	end

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept) else $error("input accepted while a frame drains");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PAYLOAD_DEPTH)) else $error("payload count overflow");

endmodule

@@ hw/rtl/scr_jobq.sv @@
// ----------------------------------------------------------------------------
// scr_jobq
// Short job queue between the input side and the output side.
// ----------------------------------------------------------------------------
module scr_jobq import scr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;

	job_t             mem_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W + 1)'(JOBQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   count_q <= (PTR_W + 1)'(count_q + 1'b1);
				2'b01:   count_q <= (PTR_W + 1)'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> !empty)) else $error("job queue overrun or underrun");

endmodule

@@ hw/rtl/scr_back.sv @@
// ----------------------------------------------------------------------------
// scr_back
// Output side: turns jobs into results and drains frame payload from RAM.
// ----------------------------------------------------------------------------
module scr_back import scr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  job_t        head,
	output logic        pop,
	output ram_rd_t     ram_rd,
	input  logic [7:0]  ram_rdata,
	output logic        frame_done,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	typedef enum logic [1:0] {
		B_IDLE  = 2'b01,
		B_DRAIN = 2'b10
	} bstate_t;

	bstate_t          state_q;
	logic [LEN_W-1:0] idx_q;
	logic [LEN_W-1:0] drain_len_q;
	logic             m_tvalid_q;
	kind_t            kind_q;
	logic [7:0]       value_q;
	logic [LEN_W-1:0] len_q;
	logic             last_q;

	logic             out_free;
	logic [LEN_W-1:0] nxt_idx;
	logic             is_last;
	logic             load_pay;
	logic             frame_start;

	always_comb begin
		out_free    = !m_tvalid_q || m_tready;
		pop         = (state_q == B_IDLE) && !q_empty && out_free;
		frame_start = pop && head.frame && (head.len != '0);
		nxt_idx     = LEN_W'(idx_q + 1'b1);
		is_last     = (nxt_idx == drain_len_q);
		load_pay    = (state_q == B_DRAIN) && out_free;
		// The next payload byte is fetched as the current one is loaded.
		ram_rd.re   = frame_start || (load_pay && !is_last);
		ram_rd.addr = (state_q == B_DRAIN) ? nxt_idx[ADDR_W-1:0] : '0;
		frame_done  = (pop && head.frame && (head.len == '0)) || (load_pay && is_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			drain_len_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (pop) begin
				m_tvalid_q <= 1'b1;
				if (frame_start) begin
					state_q     <= B_DRAIN;
					idx_q       <= '0;
					drain_len_q <= head.len;
				end
			end else if (load_pay) begin
				m_tvalid_q <= 1'b1;
				if (is_last) begin
					state_q <= B_IDLE;
				end else begin
					idx_q <= nxt_idx;
				end
			end else if (out_free) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.frame) begin
				kind_q  <= KIND_CMD;
				value_q <= head.cmd;
				len_q   <= head.len;
				last_q  <= (head.len == '0);
			end else begin
				kind_q  <= KIND_ACK;
				value_q <= ACK_CHAR;
				len_q   <= '0;
				last_q  <= 1'b1;
			end
		end else if (load_pay) begin
			kind_q  <= KIND_PAY;
			value_q <= ram_rdata;
			len_q   <= '0;
			last_q  <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - 8 - LEN_W){1'b0}}, len_q, value_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DRAIN) |-> (idx_q < drain_len_q)) else $error("drain index out of range");
	a_done_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> (m_tvalid && m_tlast)) else $error("frame end not marked last");

endmodule
